### sv/assert_macros.svh
// Assertion macros for the ring readout RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset
`define PARW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same, on the house clock and reset names
`define PARW_ASSERT_DFLT(lbl, prop, msg) \
  `PARW_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### sv/parw_pkg.sv
// Types, constants and the WAV header table for the ring readout block
`timescale 1ns / 1ps
package parw_pkg;

  localparam int unsigned RING_SAMPLES   = 16384;
  localparam int unsigned IDX_W          = 14;
  localparam int unsigned CNT_W          = 15;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned ADDR_W         = IDX_W + 1;
  localparam int unsigned HEAD_BYTES     = 44;
  localparam int unsigned FS_HZ          = 16000;
  // 1000 / FS_HZ is exactly 1/16, so ms = samples >> 4
  localparam int unsigned MS_SHIFT       = 4;
  localparam int unsigned LEN_W          = 12;
  localparam int unsigned FRAME_MS_W     = LEN_W - MS_SHIFT;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SNAP  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_DATA    = 2'd1,
    ST_NO_READOUT = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_MEM  = 1'b1
  } back_state_e;

  typedef struct packed {
    func_e                   op;
    logic signed [19:0]      sample;
    logic                    frame_last;
    logic [FRAME_MS_W-1:0]   frame_ms;
    logic [31:0]             frame_time;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [5:0] pos,
                                          input logic [CNT_W-1:0] count);
    logic [31:0] pcm_len;
    logic [31:0] riff_len;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [7:0]  b;
    pcm_len    = 32'({count, 1'b0});
    riff_len   = 32'd36 + pcm_len;
    rate       = 32'(FS_HZ);
    byte_rate  = 32'(FS_HZ * 2);
    unique case (pos)
      6'd0:  b = 8'h52;  // R
      6'd1:  b = 8'h49;  // I
      6'd2:  b = 8'h46;  // F
      6'd3:  b = 8'h46;  // F
      6'd4:  b = riff_len[7:0];
      6'd5:  b = riff_len[15:8];
      6'd6:  b = riff_len[23:16];
      6'd7:  b = riff_len[31:24];
      6'd8:  b = 8'h57;  // W
      6'd9:  b = 8'h41;  // A
      6'd10: b = 8'h56;  // V
      6'd11: b = 8'h45;  // E
      6'd12: b = 8'h66;  // f
      6'd13: b = 8'h6d;  // m
      6'd14: b = 8'h74;  // t
      6'd15: b = 8'h20;  // space
      6'd16: b = 8'd16;
      6'd20: b = 8'd1;
      6'd22: b = 8'd1;
      6'd24: b = rate[7:0];
      6'd25: b = rate[15:8];
      6'd26: b = rate[23:16];
      6'd27: b = rate[31:24];
      6'd28: b = byte_rate[7:0];
      6'd29: b = byte_rate[15:8];
      6'd30: b = byte_rate[23:16];
      6'd31: b = byte_rate[31:24];
      6'd32: b = 8'd2;
      6'd34: b = 8'd16;
      6'd36: b = 8'h64;  // d
      6'd37: b = 8'h61;  // a
      6'd38: b = 8'h74;  // t
      6'd39: b = 8'h61;  // a
      6'd40: b = pcm_len[7:0];
      6'd41: b = pcm_len[15:8];
      6'd42: b = pcm_len[23:16];
      6'd43: b = pcm_len[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

### sv/parw_if.sv
// Handshake channel interfaces for items in and results out
`timescale 1ns / 1ps
interface parw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [19:0] sample_value;
  logic               frame_last;
  logic [11:0]        frame_length;
  logic [31:0]        frame_time_ms;

  modport source (output valid, func, sample_value, frame_last, frame_length,
                  frame_time_ms, input ready);
  modport sink (input valid, func, sample_value, frame_last, frame_length,
                frame_time_ms, output ready);
endinterface

interface parw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  wav_byte;
  logic        last_byte;
  logic [15:0] total_bytes;
  logic [31:0] oldest_time_ms;

  modport source (output valid, status, wav_byte, last_byte, total_bytes,
                  oldest_time_ms, input ready);
  modport sink (input valid, status, wav_byte, last_byte, total_bytes,
                oldest_time_ms, output ready);
endinterface

### sv/parw_front.sv
// Front end: takes items, decodes func and pre-scales frame length
`timescale 1ns / 1ps
module parw_front (
  parw_in_if.sink           item_in,
  input  parw_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output parw_pkg::cmd_t    cmd_o
);

  parw_pkg::func_e op;

  assign op            = parw_pkg::func_e'(item_in.func);
  assign item_in.ready = !q_stat_i.full;
  // unused code is swallowed here and never reaches the back end
  assign push_o = item_in.valid && !q_stat_i.full && (op != parw_pkg::FUNC_NONE);

  always_comb begin
    cmd_o.op         = op;
    cmd_o.sample     = item_in.sample_value;
    cmd_o.frame_last = item_in.frame_last;
    cmd_o.frame_ms   = item_in.frame_length[parw_pkg::LEN_W-1:parw_pkg::MS_SHIFT];
    cmd_o.frame_time = item_in.frame_time_ms;
  end

endmodule

### sv/parw_queue.sv
// Two-entry command queue between front and back end
`timescale 1ns / 1ps
module parw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  parw_pkg::q_ctrl_t ctrl_i,
  input  parw_pkg::cmd_t    push_data_i,
  output parw_pkg::cmd_t    pop_data_o,
  output parw_pkg::q_stat_t stat_o
);

  parw_pkg::cmd_t ent_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1;
    rd_ptr_d = rd_ptr_q + 1'b1;
    cnt_d    = cnt_q + 2'(ctrl_i.push) - 2'(ctrl_i.pop);
  end

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (ctrl_i.push) wr_ptr_q <= wr_ptr_d;
      if (ctrl_i.pop)  rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) ent_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### sv/parw_back.sv
// Back end: ring state, sample memory, WAV readout and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module parw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        gain_i,
  input  parw_pkg::cmd_t    cmd_i,
  input  parw_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  parw_out_if.source        res_out
);

  localparam int unsigned IW = parw_pkg::IDX_W;
  localparam int unsigned CW = parw_pkg::CNT_W;
  localparam int unsigned PW = parw_pkg::POS_W;
  localparam int unsigned AW = parw_pkg::ADDR_W;

  parw_pkg::back_state_e state_q, state_d;

  logic [IW-1:0] wr_pos_q [2];
  logic [IW-1:0] wr_pos_d [2];
  logic [CW-1:0] cnt_q [2];
  logic [CW-1:0] cnt_d [2];
  logic [31:0]   stamp_q [2];
  logic [31:0]   stamp_d [2];
  logic          active_q, active_d;
  logic          ro_active_q, ro_active_d;
  logic          ro_bank_q, ro_bank_d;
  logic [PW-1:0] ro_pos_q, ro_pos_d;
  logic [IW-1:0] ro_start_q, ro_start_d;
  logic [CW-1:0] ro_count_q, ro_count_d;
  logic          pend_odd_q, pend_odd_d;
  logic          pend_last_q, pend_last_d;

  logic signed [19:0] mem_q [2 * parw_pkg::RING_SAMPLES];
  logic signed [19:0] rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  logic              out_valid_q;
  logic              out_free;
  logic              out_load;
  parw_pkg::status_e res_status_q, res_status_d;
  logic [7:0]        res_byte_q, res_byte_d;
  logic              res_last_q, res_last_d;
  logic [15:0]       res_total_q, res_total_d;
  logic [31:0]       res_time_q, res_time_d;

  logic          b;
  logic [CW-1:0] new_cnt;
  logic [CW-1:0] snap_n;
  logic [PW-1:0] ro_total;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] pos_off;
  logic [IW-1:0] rd_idx;

  logic signed [28:0] prod;
  logic signed [28:0] prod_adj;
  logic signed [24:0] scaled;
  logic [15:0]        pcm;

  assign b        = active_q;
  assign out_free = !out_valid_q || res_out.ready;
  assign new_cnt  = (cnt_q[b] == CW'(parw_pkg::RING_SAMPLES)) ? cnt_q[b]
                                                              : cnt_q[b] + 1'b1;
  assign snap_n   = cnt_q[b];
  assign ro_total = PW'(parw_pkg::HEAD_BYTES) + PW'({ro_count_q, 1'b0});
  assign pos_next = ro_pos_q + 1'b1;
  assign pos_off  = ro_pos_q - PW'(parw_pkg::HEAD_BYTES);
  // ring depth is a power of two, so the index wraps by truncation
  assign rd_idx   = ro_start_q + pos_off[IW:1];

  // sample conversion: gain, divide by 16 toward zero, clamp to 16 bits
  always_comb begin
    prod     = rdata_q * $signed({1'b0, gain_i});
    prod_adj = (prod < 0) ? prod + 29'sd15 : prod;
    scaled   = 25'(prod_adj >>> 4);
    if (scaled > 25'sd32767) begin
      pcm = 16'h7fff;
    end else if (scaled < -25'sd32768) begin
      pcm = 16'h8000;
    end else begin
      pcm = scaled[15:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    wr_pos_d     = wr_pos_q;
    cnt_d        = cnt_q;
    stamp_d      = stamp_q;
    active_d     = active_q;
    ro_active_d  = ro_active_q;
    ro_bank_d    = ro_bank_q;
    ro_pos_d     = ro_pos_q;
    ro_start_d   = ro_start_q;
    ro_count_d   = ro_count_q;
    pend_odd_d   = pend_odd_q;
    pend_last_d  = pend_last_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = {b, wr_pos_q[b]};
    mem_raddr    = {ro_bank_q, rd_idx};
    out_load     = 1'b0;
    res_status_d = parw_pkg::ST_OK;
    res_byte_d   = 8'd0;
    res_last_d   = 1'b0;
    res_total_d  = 16'd0;
    res_time_d   = 32'd0;

    unique case (state_q)
      parw_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          unique case (cmd_i.op)
            parw_pkg::FUNC_WRITE: begin
              pop_o       = 1'b1;
              mem_we      = 1'b1;
              wr_pos_d[b] = wr_pos_q[b] + 1'b1;
              cnt_d[b]    = new_cnt;
              if (cmd_i.frame_last) begin
                stamp_d[b] = cmd_i.frame_time + 32'(cmd_i.frame_ms)
                           - 32'(new_cnt >> parw_pkg::MS_SHIFT);
              end
            end
            parw_pkg::FUNC_SNAP: begin
              if (out_free) begin
                pop_o    = 1'b1;
                out_load = 1'b1;
                if (snap_n == '0) begin
                  res_status_d = parw_pkg::ST_NO_DATA;
                end else begin
                  ro_start_d   = (snap_n == CW'(parw_pkg::RING_SAMPLES)) ? wr_pos_q[b]
                                                                        : '0;
                  ro_count_d   = snap_n;
                  ro_bank_d    = b;
                  ro_pos_d     = '0;
                  ro_active_d  = 1'b1;
                  wr_pos_d[~b] = '0;
                  cnt_d[~b]    = '0;
                  stamp_d[~b]  = 32'd0;
                  active_d     = ~b;
                  res_total_d  = 16'(parw_pkg::HEAD_BYTES) + 16'({snap_n, 1'b0});
                  res_time_d   = stamp_q[b];
                end
              end
            end
            parw_pkg::FUNC_READ: begin
              if (out_free) begin
                pop_o = 1'b1;
                if (!ro_active_q) begin
                  out_load     = 1'b1;
                  res_status_d = parw_pkg::ST_NO_READOUT;
                end else begin
                  ro_pos_d = pos_next;
                  if (pos_next == ro_total) ro_active_d = 1'b0;
                  if (ro_pos_q < PW'(parw_pkg::HEAD_BYTES)) begin
                    out_load   = 1'b1;
                    res_byte_d = parw_pkg::hdr_byte(ro_pos_q[5:0], ro_count_q);
                    res_last_d = (pos_next == ro_total);
                  end else begin
                    // sample byte: fetch from the ring, finish in BK_MEM once the result register is free
                    mem_re      = 1'b1;
                    pend_odd_d  = pos_off[0];
                    pend_last_d = (pos_next == ro_total);
                    state_d     = parw_pkg::BK_MEM;
                  end
                end
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      parw_pkg::BK_MEM: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_byte_d = pend_odd_q ? pcm[15:8] : pcm[7:0];
          res_last_d = pend_last_q;
          state_d    = parw_pkg::BK_IDLE;
        end
      end
      default: state_d = parw_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= parw_pkg::BK_IDLE;
      for (int i = 0; i < 2; i++) begin
        wr_pos_q[i] <= '0;
        cnt_q[i]    <= '0;
        stamp_q[i]  <= 32'd0;
      end
      active_q    <= 1'b0;
      ro_active_q <= 1'b0;
      ro_bank_q   <= 1'b0;
      ro_pos_q    <= '0;
      ro_start_q  <= '0;
      ro_count_q  <= '0;
      pend_odd_q  <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pos_q    <= wr_pos_d;
      cnt_q       <= cnt_d;
      stamp_q     <= stamp_d;
      active_q    <= active_d;
      ro_active_q <= ro_active_d;
      ro_bank_q   <= ro_bank_d;
      ro_pos_q    <= ro_pos_d;
      ro_start_q  <= ro_start_d;
      ro_count_q  <= ro_count_d;
      pend_odd_q  <= pend_odd_d;
      pend_last_q <= pend_last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_status_q <= res_status_d;
      res_byte_q   <= res_byte_d;
      res_last_q   <= res_last_d;
      res_total_q  <= res_total_d;
      res_time_q   <= res_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= cmd_i.sample;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.status         = res_status_q;
  assign res_out.wav_byte       = res_byte_q;
  assign res_out.last_byte      = res_last_q;
  assign res_out.total_bytes    = res_total_q;
  assign res_out.oldest_time_ms = res_time_q;

  `PARW_ASSERT_DFLT(a_pop_idle, pop_o |-> (state_q == parw_pkg::BK_IDLE), "pop outside idle")
  `PARW_ASSERT_DFLT(a_cnt_cap, (cnt_q[0] <= CW'(parw_pkg::RING_SAMPLES)) && (cnt_q[1] <= CW'(parw_pkg::RING_SAMPLES)), "count above ring size")
  `PARW_ASSERT_DFLT(a_ro_nonempty, ro_active_q |-> (ro_count_q != '0), "readout of empty bank")
  `PARW_ASSERT_DFLT(a_ro_pos, ro_active_q |-> (ro_pos_q < ro_total), "readout past image end")

endmodule

### sv/pingpong_audio_ring_wav_readout.sv
// Ping-pong audio rings with WAV byte readout, top level
// Timing: a write item is taken in the back end's idle state and gives no result; a snapshot
// or header read loads the result register as it leaves the queue, valid the cycle after; a
// sample read passes the registered sample memory port and BK_MEM first. Throughput: one
// write per cycle while idle; results go one at a time through the single result register.
// Reset is asynchronous, active low: rings empty, no readout, gain 16; memory is not cleared.
`timescale 1ns / 1ps
module pingpong_audio_ring_wav_readout (
  input  logic       clk_i,
  input  logic       rst_ni,
  parw_in_if.sink    item_in,
  parw_out_if.source res_out,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic              [7:0] gain_q;
  logic              push;
  parw_pkg::cmd_t    push_cmd;
  parw_pkg::cmd_t    pop_cmd;
  parw_pkg::q_ctrl_t q_ctrl;
  parw_pkg::q_stat_t q_stat;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 8'd16;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  parw_front u_front (
    .item_in  (item_in),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  parw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .push_data_i (push_cmd),
    .pop_data_o  (pop_cmd),
    .stat_o      (q_stat)
  );

  parw_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gain_i   (gain_q),
    .cmd_i    (pop_cmd),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res_out  (res_out)
  );

endmodule

### sim/tb_pingpong_audio_ring_wav_readout.sv
// Testbench for the ping-pong audio rings with WAV readout: predicted bytes against the block
`timescale 1ns / 1ps
module tb_pingpong_audio_ring_wav_readout;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  wav_byte;
    logic        last_byte;
    logic [15:0] total_bytes;
    logic [31:0] oldest_time_ms;
  } wav_res_t;

  localparam int RING = 16384;
  localparam int LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  parw_in_if item_in ();
  parw_out_if res_out ();

  pingpong_audio_ring_wav_readout dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_in(item_in), .res_out(res_out),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [19:0] ring_mem [0:2*RING-1];
  int unsigned wr_pos [2];
  int unsigned kept [2];
  logic [31:0] stamp [2];
  int unsigned act_bank;
  bit rd_on;
  int unsigned rd_bank, rd_pos, rd_start, rd_cnt;
  int unsigned gain = 16;

  wav_res_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  int sink_hold = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] head_byte(int unsigned p, int unsigned n);
    logic [31:0] db;
    logic [31:0] w;
    db = 32'(n * 2);
    case (p)
      0: return "R"; 1: return "I"; 2, 3: return "F";
      8: return "W"; 9: return "A"; 10: return "V"; 11: return "E";
      12: return "f"; 13: return "m"; 14: return "t"; 15: return " ";
      16, 34: return 8'd16; 20, 22: return 8'd1; 32: return 8'd2;
      36: return "d"; 37: return "a"; 38: return "t"; 39: return "a";
      default: ;
    endcase
    if (p >= 4 && p < 8) begin
      w = 32'd36 + db;
      return w[8*(p-4) +: 8];
    end
    if (p >= 24 && p < 28) begin
      w = 32'd16000;
      return w[8*(p-24) +: 8];
    end
    if (p >= 28 && p < 32) begin
      w = 32'd32000;
      return w[8*(p-28) +: 8];
    end
    if (p >= 40) return db[8*(p-40) +: 8];
    return 8'd0;
  endfunction

  function automatic logic [15:0] scale_pcm(logic signed [19:0] s);
    longint v;
    v = (longint'(s) * longint'(gain)) / 16;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic predict(logic [1:0] f, logic signed [19:0] s, logic fl,
                         logic [11:0] len, logic [31:0] t);
    wav_res_t r;
    int unsigned b, idx, o;
    logic [15:0] pcm;
    r = '0;
    b = act_bank;
    if (f == parw_pkg::FUNC_WRITE) begin
      ring_mem[b*RING + wr_pos[b]] = s;
      wr_pos[b] = (wr_pos[b] + 1) % RING;
      if (kept[b] < RING) kept[b]++;
      if (fl) stamp[b] = t + 32'((len * 1000) / 16000) - 32'((kept[b] * 1000) / 16000);
    end else if (f == parw_pkg::FUNC_SNAP) begin
      if (kept[b] == 0) r.status = parw_pkg::ST_NO_DATA;
      else begin
        o = b ^ 1;
        rd_start = (kept[b] == RING) ? wr_pos[b] : 0;
        rd_cnt = kept[b]; rd_bank = b; rd_pos = 0; rd_on = 1'b1;
        wr_pos[o] = 0; kept[o] = 0; stamp[o] = 0; act_bank = o;
        r.total_bytes = 16'(44 + 2 * rd_cnt);
        r.oldest_time_ms = stamp[b];
      end
      expected_q.push_back(r);
    end else if (f == parw_pkg::FUNC_READ) begin
      if (!rd_on) r.status = parw_pkg::ST_NO_READOUT;
      else begin
        if (rd_pos < 44) r.wav_byte = head_byte(rd_pos, rd_cnt);
        else begin
          idx = (rd_start + (rd_pos - 44) / 2) % RING;
          pcm = scale_pcm(ring_mem[rd_bank*RING + idx]);
          r.wav_byte = ((rd_pos - 44) & 1) ? pcm[15:8] : pcm[7:0];
        end
        rd_pos++;
        if (rd_pos >= 44 + 2 * rd_cnt) begin
          r.last_byte = 1'b1; rd_on = 1'b0;
        end
      end
      expected_q.push_back(r);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    wav_res_t got, exp_r;
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && res_out.valid && res_out.ready) begin
      got = '{res_out.status, res_out.wav_byte, res_out.last_byte,
              res_out.total_bytes, res_out.oldest_time_ms};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %h got %h", exp_r, got);
        end
      end
    end
  end

  // sink stalls come in bursts of random length
  always @(negedge clk_i) begin
    if (quiet) begin
      sink_hold = 0;
      res_out.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
      res_out.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 7) - 1;
      res_out.ready <= 1'b0;
    end else begin
      res_out.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] f, logic signed [19:0] s = '0, logic fl = 1'b0,
                           logic [11:0] len = '0, logic [31:0] t = '0);
    int g;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      g = $urandom_range(1, 7);
      item_in.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    item_in.valid <= 1'b1;
    item_in.func <= f; item_in.sample_value <= s; item_in.frame_last <= fl;
    item_in.frame_length <= len; item_in.frame_time_ms <= t;
    do @(posedge clk_i); while (!item_in.ready);
    predict(f, s, fl, len, t);
    // valid stays up; the next send or a drain sets it at this falling edge
    @(negedge clk_i);
  endtask

  task automatic drain();
    item_in.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_gain(int unsigned g);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= 8'(g);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gain = g;
  endtask

  task automatic read_image(int max_bytes);
    int k;
    k = 0;
    while (rd_on && k < max_bytes) begin
      send_item(parw_pkg::FUNC_READ);
      k++;
    end
  endtask

  task automatic test_directed();
    send_item(parw_pkg::FUNC_READ);                // no readout
    send_item(parw_pkg::FUNC_SNAP);                // empty bank
    send_item(parw_pkg::FUNC_WRITE, 20'sh7FFFF);
    send_item(parw_pkg::FUNC_WRITE, 20'sh80000);
    send_item(parw_pkg::FUNC_WRITE, 20'sd0, 1'b1, 12'hFFF, 32'hFFFF_FFFF);
    send_item(parw_pkg::FUNC_WRITE, -20'sd1, 1'b1, 12'd0, 32'd0);   // stamp back to zero
    send_item(parw_pkg::FUNC_NONE, 20'sh5A5A5, 1'b1, 12'hABC, 32'h1234_5678);
    send_item(parw_pkg::FUNC_SNAP);
    read_image(60);
    send_item(parw_pkg::FUNC_READ);                // past the end
    set_gain(255);
    send_item(parw_pkg::FUNC_WRITE, 20'sd300);
    send_item(parw_pkg::FUNC_WRITE, -20'sd300);
    send_item(parw_pkg::FUNC_SNAP);
    read_image(60);
    set_gain(0);
  endtask

  task automatic rand_write();
    logic [19:0] v;
    v = 20'($urandom());
    if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
    send_item(parw_pkg::FUNC_WRITE, v, $urandom_range(0, 3) == 0, 12'($urandom()),
              $urandom());
  endtask

  task automatic test_random(int n_items);
    int sent, w, r;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(0, 20);
      repeat (w) begin rand_write(); sent++; end
      send_item(parw_pkg::FUNC_SNAP); sent++;
      r = $urandom_range(0, 3) == 0 ? 20 : 200;
      repeat ($urandom_range(1, r)) begin
        case ($urandom_range(0, 9))
          0: send_item(parw_pkg::FUNC_NONE, 20'($urandom()), 1'($urandom()),
                       12'($urandom()), $urandom());
          1: begin rand_write(); sent++; end
          2: begin send_item(parw_pkg::FUNC_SNAP); sent++; end
          default: begin send_item(parw_pkg::FUNC_READ); sent++; end
        endcase
      end
      if ($urandom_range(0, 40) == 0) set_gain($urandom_range(0, 255));
    end
  endtask

  // long write burst, partial readout, then a snapshot of the fresh empty bank
  task automatic test_long_burst();
    repeat (150) rand_write();
    send_item(parw_pkg::FUNC_SNAP);
    read_image(100);
    drain();                             // sender holds off until all results are in
    send_item(parw_pkg::FUNC_SNAP);      // other bank is empty
  endtask

  initial begin
    item_in.valid = 1'b0; item_in.func = parw_pkg::FUNC_WRITE; item_in.sample_value = '0;
    item_in.frame_last = 1'b0; item_in.frame_length = '0; item_in.frame_time_ms = '0;
    res_out.ready = 1'b0;
    for (int i = 0; i < 2*RING; i++) ring_mem[i] = '0;
    wr_pos = '{0, 0}; kept = '{0, 0}; stamp = '{0, 0};
    act_bank = 0; rd_on = 0; rd_bank = 0; rd_pos = 0; rd_start = 0; rd_cnt = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(700);
    set_gain(16);
    test_long_burst();
    set_gain(128);
    test_random(450);
    quiet = 1'b1;
    set_gain(200);
    test_random(250);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/parw_pkg.sv
sv/parw_if.sv
sv/parw_front.sv
sv/parw_queue.sv
sv/parw_back.sv
sv/pingpong_audio_ring_wav_readout.sv
sim/tb_pingpong_audio_ring_wav_readout.sv
